/* hdl/sdtp_pkg.sv */
`timescale 1ns / 1ps
package sdtp_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 16;
  localparam int unsigned ID_BITS_DEF      = 16;
  localparam int unsigned RESULT_CAP       = 16;
  localparam int unsigned CFG_W            = 5;
  localparam int unsigned TIME_W           = 32;

  typedef enum logic [1:0] {
    MODE_SCHED  = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CHECK  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCHED,
    S_KEY,
    S_INS,
    S_FIND,
    S_CANCEL,
    S_CHK,
    S_EMIT,
    S_UNL,
    S_RESP,
    S_FLUSH
  } state_e;

  // Result of the shared deadline unit.
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] diff;
    logic              le;
  } alu_res_t;

endpackage

/* hdl/sdtp_alu.sv */
`timescale 1ns / 1ps
module sdtp_alu (
  input  logic [sdtp_pkg::TIME_W-1:0] base_i,
  input  logic [sdtp_pkg::TIME_W-1:0] delay_i,
  input  logic [sdtp_pkg::TIME_W-1:0] key_i,
  output sdtp_pkg::alu_res_t          res_o
);
  import sdtp_pkg::*;

  logic [TIME_W-1:0] sum;

  // The deadline wraps modulo 2^32 and is then compared as a plain value.
  assign sum        = base_i + delay_i;
  assign res_o.sum  = sum;
  assign res_o.diff = sum - key_i;
  assign res_o.le   = (sum <= key_i);

endmodule

/* hdl/sorted_deadline_timer_pool.sv */
`timescale 1ns / 1ps
// Sorted deadline timer pool.
// Input channel (in_valid_i/in_ready_o) carries one request per transfer:
// schedule, cancel, query time left, or check expirations. The output
// channel (out_valid_o/out_ready_i) carries the results; last_o marks the
// final result of a request. A check that finds nothing expired gives none.
// Configuration: cfg_we_i writes max_per_check at any edge; zero or any
// value above 16 means sixteen results per check.
// A request walks the deadline-ordered linked list one entry per cycle
// through a single deadline adder/comparator. Schedule walks to its insert
// point, query and cancel search for the id, and a check unlinks each
// expired timer and walks a repeating one back in at its new deadline.
// The block takes one request at a time; in_ready_o is high only when idle.
// Results sit in an output register, so a stalled receiver stalls only the
// step that produces the next result. Reset empties the active list, chains
// all entries onto the free list and restarts ids at zero; no clearing pass.
module sorted_deadline_timer_pool #(
  parameter int unsigned POOL_ENTRIES = sdtp_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned ID_BITS      = sdtp_pkg::ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sdtp_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [sdtp_pkg::TIME_W-1:0] now_i,
  input  logic [sdtp_pkg::TIME_W-1:0] delay_i,
  input  logic [ID_BITS-1:0]          timer_id_i,
  input  logic                        repeat_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ID_BITS-1:0]          result_id_o,
  output logic [1:0]                  status_o,
  output logic [sdtp_pkg::TIME_W-1:0] time_left_o,
  output logic                        fired_o,
  output logic                        last_o
);
  import sdtp_pkg::*;

  localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  // Entry store.
  logic [ID_BITS-1:0] ident_q [POOL_ENTRIES];
  logic [TIME_W-1:0]  base_q  [POOL_ENTRIES];
  logic [TIME_W-1:0]  dly_q   [POOL_ENTRIES];
  logic               rep_q   [POOL_ENTRIES];
  logic [LW-1:0]      link_q  [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] seen_q;

  logic [LW-1:0] head_q, free_q;
  logic [ID_BITS-1:0] nid_q;
  logic [CFG_W-1:0] cfg_q;

  state_e state_q, state_d;

  // Request registers.
  mode_e              mode_q;
  logic [TIME_W-1:0]  now_q, delay_q, key_q;
  logic [ID_BITS-1:0] tid_q;
  logic               rreq_q, rep_e_q;
  logic [CFG_W-1:0]   lim_q, n_q;
  logic [LW-1:0]      cur_q, nxt_q, prev_q, eye_q, e_q;

  // Single-result and held check results.
  logic [ID_BITS-1:0] rid_q, hold_id_q;
  status_e            rst_q;
  logic [TIME_W-1:0]  left_q;
  logic               hold_v_q;

  logic [ID_BITS-1:0] out_id_q;
  logic [1:0]         out_st_q;
  logic [TIME_W-1:0]  out_left_q;
  logic               out_valid_q, out_fired_q, out_last_q;

  logic [LW-1:0] rd_ptr;
  logic [IW-1:0] rd_idx, e_idx, p_idx;
  logic [ID_BITS-1:0] rd_ident;
  logic [LW-1:0] rd_link;
  alu_res_t alu;
  logic [TIME_W-1:0] alu_key;
  logic cur_ok, eye_ok, out_free, accept, id_match;
  logic load_resp, load_hold, load_last;
  logic [CFG_W-1:0] eff_lim;

  always_comb begin
    unique case (state_q)
      S_FIND, S_CHK: rd_ptr = cur_q;
      S_UNL, S_INS:  rd_ptr = eye_q;
      default:       rd_ptr = e_q;
    endcase
  end

  assign rd_idx   = rd_ptr[IW-1:0];
  assign e_idx    = e_q[IW-1:0];
  assign p_idx    = prev_q[IW-1:0];
  assign rd_ident = ident_q[rd_idx];
  assign rd_link  = link_q[rd_idx];
  assign cur_ok   = (cur_q < NIL);
  assign eye_ok   = (eye_q < NIL);
  assign id_match = (rd_ident == tid_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign alu_key  = (state_q == S_INS) ? key_q : now_q;
  assign eff_lim  = (cfg_q == '0 || cfg_q > CFG_W'(RESULT_CAP)) ? CFG_W'(RESULT_CAP) : cfg_q;

  sdtp_alu u_alu (
    .base_i  (base_q[rd_idx]),
    .delay_i (dly_q[rd_idx]),
    .key_i   (alu_key),
    .res_o   (alu)
  );

  assign load_resp = (state_q == S_RESP) && out_free;
  assign load_hold = (state_q == S_EMIT) && hold_v_q && out_free;
  assign load_last = (state_q == S_FLUSH) && hold_v_q && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_e'(mode_i))
            MODE_SCHED:              state_d = (free_q == NIL) ? S_RESP : S_SCHED;
            MODE_CANCEL, MODE_QUERY: state_d = S_FIND;
            MODE_CHECK:              state_d = S_CHK;
          endcase
        end
      end
      S_SCHED: state_d = S_KEY;
      S_KEY:   state_d = S_INS;
      S_INS: begin
        if (!(eye_ok && alu.le)) begin
          state_d = (mode_q == MODE_CHECK) ? S_CHK : S_RESP;
        end
      end
      S_FIND: begin
        if (!cur_ok) begin
          state_d = S_RESP;
        end else if (id_match) begin
          state_d = (mode_q == MODE_CANCEL) ? S_CANCEL : S_RESP;
        end
      end
      S_CANCEL: state_d = S_RESP;
      S_CHK: begin
        if (!cur_ok || n_q == lim_q || !alu.le) begin
          state_d = S_FLUSH;
        end else if (!seen_q[rd_idx]) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: if (!hold_v_q || out_free) state_d = S_UNL;
      S_UNL: begin
        if (eye_q == e_q || !eye_ok) begin
          state_d = rep_e_q ? S_KEY : S_CHK;
        end
      end
      S_RESP:  if (out_free) state_d = S_IDLE;
      S_FLUSH: if (!hold_v_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Control state: list heads, links, ids, seen marks, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL;
      free_q      <= '0;
      nid_q       <= '0;
      cfg_q       <= '0;
      seen_q      <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        link_q[i] <= LW'(i + 1);
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (load_resp || load_hold || load_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (mode_e'(mode_i) == MODE_SCHED) nid_q <= nid_q + 1'b1;
            if (mode_e'(mode_i) == MODE_CHECK) begin
              seen_q   <= '0;
              hold_v_q <= 1'b0;
            end
          end
        end
        S_SCHED: free_q <= rd_link;
        S_INS: begin
          if (!(eye_ok && alu.le)) begin
            if (prev_q == NIL) head_q <= e_q;
            else               link_q[p_idx] <= e_q;
            link_q[e_idx] <= eye_q;
          end
        end
        S_CANCEL: begin
          if (prev_q == NIL) head_q <= nxt_q;
          else               link_q[p_idx] <= nxt_q;
          link_q[e_idx] <= free_q;
          free_q        <= e_q;
        end
        S_CHK: begin
          if (state_d == S_EMIT) seen_q[rd_idx] <= 1'b1;
        end
        S_EMIT: if (state_d == S_UNL) hold_v_q <= 1'b1;
        S_UNL: begin
          if (eye_q == e_q) begin
            if (prev_q == NIL) head_q <= nxt_q;
            else               link_q[p_idx] <= nxt_q;
            if (!rep_e_q) begin
              link_q[e_idx] <= free_q;
              free_q        <= e_q;
            end
          end
        end
        S_FLUSH: if (load_last) hold_v_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Payload: entry fields, walk pointers, results.
  always_ff @(posedge clk_i) begin
    if (load_resp) begin
      out_id_q    <= rid_q;
      out_st_q    <= rst_q;
      out_left_q  <= left_q;
      out_fired_q <= 1'b0;
      out_last_q  <= 1'b1;
    end else if (load_hold || load_last) begin
      out_id_q    <= hold_id_q;
      out_st_q    <= ST_OK;
      out_left_q  <= '0;
      out_fired_q <= 1'b1;
      out_last_q  <= load_last;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_q  <= mode_e'(mode_i);
          now_q   <= now_i;
          delay_q <= delay_i;
          tid_q   <= timer_id_i;
          rreq_q  <= repeat_req_i;
          lim_q   <= eff_lim;
          n_q     <= '0;
          cur_q   <= head_q;
          prev_q  <= NIL;
          e_q     <= free_q;
          rid_q   <= nid_q;
          rst_q   <= (free_q == NIL) ? ST_FULL : ST_OK;
          left_q  <= '0;
        end
      end
      S_SCHED: begin
        ident_q[e_idx] <= rid_q;
        base_q[e_idx]  <= now_q;
        dly_q[e_idx]   <= delay_q;
        rep_q[e_idx]   <= rreq_q;
      end
      S_KEY: begin
        key_q  <= alu.sum;
        eye_q  <= head_q;
        prev_q <= NIL;
      end
      S_INS: begin
        if (eye_ok && alu.le) begin
          prev_q <= eye_q;
          eye_q  <= rd_link;
        end else begin
          cur_q <= nxt_q;
        end
      end
      S_FIND: begin
        if (!cur_ok) begin
          rid_q  <= tid_q;
          rst_q  <= ST_NOT_FOUND;
          left_q <= (mode_q == MODE_QUERY) ? '1 : '0;
        end else if (id_match) begin
          rid_q  <= tid_q;
          rst_q  <= ST_OK;
          nxt_q  <= rd_link;
          e_q    <= cur_q;
          left_q <= (mode_q == MODE_QUERY && !alu.le) ? alu.diff : '0;
        end else begin
          prev_q <= cur_q;
          cur_q  <= rd_link;
        end
      end
      S_CHK: begin
        if (state_d == S_CHK) begin
          cur_q <= rd_link;
        end else if (state_d == S_EMIT) begin
          nxt_q   <= rd_link;
          e_q     <= cur_q;
          n_q     <= n_q + 1'b1;
          rep_e_q <= rep_q[rd_idx];
        end
      end
      S_EMIT: begin
        if (state_d == S_UNL) begin
          hold_id_q <= rd_ident;
          eye_q     <= head_q;
          prev_q    <= NIL;
        end
      end
      S_UNL: begin
        if (eye_q == e_q || !eye_ok) begin
          if (rep_e_q) base_q[e_idx] <= now_q;
          else         cur_q <= nxt_q;
        end else begin
          prev_q <= eye_q;
          eye_q  <= rd_link;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = out_id_q;
  assign status_o    = out_st_q;
  assign time_left_o = out_left_q;
  assign fired_o     = out_fired_q;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  // The active and free lists never share a head entry.
  a_heads_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == free_q) |-> (head_q == NIL))
    else $error("active and free lists share an entry");

  // A check never reports more than its cap.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && mode_q == MODE_CHECK) |-> (n_q <= lim_q))
    else $error("check result count above limit");

  // A held check result exists only while a check is in progress.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q && state_q != S_IDLE |-> mode_q == MODE_CHECK)
    else $error("held result outside a check");

  // An accepted request always keeps the block busy for the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after a transfer");
`endif

endmodule
